// ===== design/btgr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btgr_pkg
// Shared types, constants, font ROM and coordinate helpers for the
// bitmap text glyph rasterizer.
// ----------------------------------------------------------------------------
package btgr_pkg;

	localparam int COORD_BITS  = 16;
	localparam int SCALE_BITS  = 4;
	localparam int GLYPH_BITS  = 7;
	localparam int COL_BITS    = 3;
	localparam int MASK_BITS   = 7;
	localparam int OFFS_BITS   = 7;   // holds 6 * 15
	localparam int NUM_COLS    = 5;
	localparam int QDEPTH      = 4;
	localparam int QPTR_BITS   = $clog2(QDEPTH);
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [7:0] FIRST_PRINT = 8'd32;
	localparam logic [7:0] LAST_PRINT  = 8'd126;
	localparam logic [7:0] LEAD_LOW    = 8'hC0;
	localparam logic [7:0] LEAD_HIGH   = 8'hFD;
	localparam logic [1:0] CONT_TAG    = 2'b10;
	localparam logic [GLYPH_BITS-1:0] QMARK_GLYPH = GLYPH_BITS'(63 - 32);
	localparam logic [COL_BITS-1:0]   LAST_COL    = COL_BITS'(NUM_COLS - 1);

	localparam logic [CFG_IDX_BITS-1:0] REG_START_X     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_Y     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_SCALE = 2'd2;

	localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// One queued glyph: which glyph and where its first column lands.
	typedef struct packed {
		logic [GLYPH_BITS-1:0] glyph;
		coord_t                base_x;
	} glyph_entry_t;

	typedef logic [NUM_COLS-1:0][MASK_BITS-1:0] glyph_cols_t;

	// Add a small unsigned offset and clamp to the signed coordinate range.
	function automatic coord_t sat_add(input coord_t base, input logic [OFFS_BITS-1:0] offs);
		logic signed [COORD_BITS:0] sum;
		sum = {base[COORD_BITS-1], base} + $signed({{(COORD_BITS+1-OFFS_BITS){1'b0}}, offs});
		if (sum[COORD_BITS] != sum[COORD_BITS-1])
			sat_add = sum[COORD_BITS] ? COORD_MIN : COORD_MAX;
		else
			sat_add = sum[COORD_BITS-1:0];
	endfunction

	// 5x7 font, columns listed left to right (column 0 at index 4).
	function automatic glyph_cols_t font_rom(input logic [GLYPH_BITS-1:0] g);
		case (g)
			7'd0:  font_rom = {7'h00,7'h00,7'h00,7'h00,7'h00};
			7'd1:  font_rom = {7'h00,7'h00,7'h5F,7'h00,7'h00};
			7'd2:  font_rom = {7'h00,7'h07,7'h00,7'h07,7'h00};
			7'd3:  font_rom = {7'h14,7'h7F,7'h14,7'h7F,7'h14};
			7'd4:  font_rom = {7'h24,7'h2A,7'h7F,7'h2A,7'h12};
			7'd5:  font_rom = {7'h23,7'h13,7'h08,7'h64,7'h62};
			7'd6:  font_rom = {7'h36,7'h49,7'h55,7'h22,7'h50};
			7'd7:  font_rom = {7'h00,7'h05,7'h03,7'h00,7'h00};
			7'd8:  font_rom = {7'h00,7'h1C,7'h22,7'h41,7'h00};
			7'd9:  font_rom = {7'h00,7'h41,7'h22,7'h1C,7'h00};
			7'd10: font_rom = {7'h14,7'h08,7'h3E,7'h08,7'h14};
			7'd11: font_rom = {7'h08,7'h08,7'h3E,7'h08,7'h08};
			7'd12: font_rom = {7'h00,7'h50,7'h30,7'h00,7'h00};
			7'd13: font_rom = {7'h08,7'h08,7'h08,7'h08,7'h08};
			7'd14: font_rom = {7'h00,7'h60,7'h60,7'h00,7'h00};
			7'd15: font_rom = {7'h20,7'h10,7'h08,7'h04,7'h02};
			7'd16: font_rom = {7'h3E,7'h51,7'h49,7'h45,7'h3E};
			7'd17: font_rom = {7'h00,7'h42,7'h7F,7'h40,7'h00};
			7'd18: font_rom = {7'h42,7'h61,7'h51,7'h49,7'h46};
			7'd19: font_rom = {7'h21,7'h41,7'h45,7'h4B,7'h31};
			7'd20: font_rom = {7'h18,7'h14,7'h12,7'h7F,7'h10};
			7'd21: font_rom = {7'h27,7'h45,7'h45,7'h45,7'h39};
			7'd22: font_rom = {7'h3C,7'h4A,7'h49,7'h49,7'h30};
			7'd23: font_rom = {7'h01,7'h71,7'h09,7'h05,7'h03};
			7'd24: font_rom = {7'h36,7'h49,7'h49,7'h49,7'h36};
			7'd25: font_rom = {7'h06,7'h49,7'h49,7'h29,7'h1E};
			7'd26: font_rom = {7'h00,7'h36,7'h36,7'h00,7'h00};
			7'd27: font_rom = {7'h00,7'h56,7'h36,7'h00,7'h00};
			7'd28: font_rom = {7'h08,7'h14,7'h22,7'h41,7'h00};
			7'd29: font_rom = {7'h14,7'h14,7'h14,7'h14,7'h14};
			7'd30: font_rom = {7'h00,7'h41,7'h22,7'h14,7'h08};
			7'd31: font_rom = {7'h02,7'h01,7'h51,7'h09,7'h06};
			7'd32: font_rom = {7'h32,7'h49,7'h79,7'h41,7'h3E};
			7'd33: font_rom = {7'h7E,7'h11,7'h11,7'h11,7'h7E};
			7'd34: font_rom = {7'h7F,7'h49,7'h49,7'h49,7'h36};
			7'd35: font_rom = {7'h3E,7'h41,7'h41,7'h41,7'h22};
			7'd36: font_rom = {7'h7F,7'h41,7'h41,7'h22,7'h1C};
			7'd37: font_rom = {7'h7F,7'h49,7'h49,7'h49,7'h41};
			7'd38: font_rom = {7'h7F,7'h09,7'h09,7'h09,7'h01};
			7'd39: font_rom = {7'h3E,7'h41,7'h49,7'h49,7'h7A};
			7'd40: font_rom = {7'h7F,7'h08,7'h08,7'h08,7'h7F};
			7'd41: font_rom = {7'h00,7'h41,7'h7F,7'h41,7'h00};
			7'd42: font_rom = {7'h20,7'h40,7'h41,7'h3F,7'h01};
			7'd43: font_rom = {7'h7F,7'h08,7'h14,7'h22,7'h41};
			7'd44: font_rom = {7'h7F,7'h40,7'h40,7'h40,7'h40};
			7'd45: font_rom = {7'h7F,7'h02,7'h0C,7'h02,7'h7F};
			7'd46: font_rom = {7'h7F,7'h04,7'h08,7'h10,7'h7F};
			7'd47: font_rom = {7'h3E,7'h41,7'h41,7'h41,7'h3E};
			7'd48: font_rom = {7'h7F,7'h09,7'h09,7'h09,7'h06};
			7'd49: font_rom = {7'h3E,7'h41,7'h51,7'h21,7'h5E};
			7'd50: font_rom = {7'h7F,7'h09,7'h19,7'h29,7'h46};
			7'd51: font_rom = {7'h46,7'h49,7'h49,7'h49,7'h31};
			7'd52: font_rom = {7'h01,7'h01,7'h7F,7'h01,7'h01};
			7'd53: font_rom = {7'h3F,7'h40,7'h40,7'h40,7'h3F};
			7'd54: font_rom = {7'h1F,7'h20,7'h40,7'h20,7'h1F};
			7'd55: font_rom = {7'h3F,7'h40,7'h38,7'h40,7'h3F};
			7'd56: font_rom = {7'h63,7'h14,7'h08,7'h14,7'h63};
			7'd57: font_rom = {7'h07,7'h08,7'h70,7'h08,7'h07};
			7'd58: font_rom = {7'h61,7'h51,7'h49,7'h45,7'h43};
			7'd59: font_rom = {7'h00,7'h7F,7'h41,7'h41,7'h00};
			7'd60: font_rom = {7'h02,7'h04,7'h08,7'h10,7'h20};
			7'd61: font_rom = {7'h00,7'h41,7'h41,7'h7F,7'h00};
			7'd62: font_rom = {7'h04,7'h02,7'h01,7'h02,7'h04};
			7'd63: font_rom = {7'h40,7'h40,7'h40,7'h40,7'h40};
			7'd64: font_rom = {7'h00,7'h01,7'h02,7'h04,7'h00};
			7'd65: font_rom = {7'h20,7'h54,7'h54,7'h54,7'h78};
			7'd66: font_rom = {7'h7F,7'h48,7'h44,7'h44,7'h38};
			7'd67: font_rom = {7'h38,7'h44,7'h44,7'h44,7'h20};
			7'd68: font_rom = {7'h38,7'h44,7'h44,7'h48,7'h7F};
			7'd69: font_rom = {7'h38,7'h54,7'h54,7'h54,7'h18};
			7'd70: font_rom = {7'h08,7'h7E,7'h09,7'h01,7'h02};
			7'd71: font_rom = {7'h0C,7'h52,7'h52,7'h52,7'h3E};
			7'd72: font_rom = {7'h7F,7'h08,7'h04,7'h04,7'h78};
			7'd73: font_rom = {7'h00,7'h44,7'h7D,7'h40,7'h00};
			7'd74: font_rom = {7'h20,7'h40,7'h44,7'h3D,7'h00};
			7'd75: font_rom = {7'h7F,7'h10,7'h28,7'h44,7'h00};
			7'd76: font_rom = {7'h00,7'h41,7'h7F,7'h40,7'h00};
			7'd77: font_rom = {7'h7C,7'h04,7'h18,7'h04,7'h78};
			7'd78: font_rom = {7'h7C,7'h08,7'h04,7'h04,7'h78};
			7'd79: font_rom = {7'h38,7'h44,7'h44,7'h44,7'h38};
			7'd80: font_rom = {7'h7C,7'h14,7'h14,7'h14,7'h08};
			7'd81: font_rom = {7'h08,7'h14,7'h14,7'h18,7'h7C};
			7'd82: font_rom = {7'h7C,7'h08,7'h04,7'h04,7'h08};
			7'd83: font_rom = {7'h48,7'h54,7'h54,7'h54,7'h20};
			7'd84: font_rom = {7'h04,7'h3F,7'h44,7'h40,7'h20};
			7'd85: font_rom = {7'h3C,7'h40,7'h40,7'h20,7'h7C};
			7'd86: font_rom = {7'h1C,7'h20,7'h40,7'h20,7'h1C};
			7'd87: font_rom = {7'h3C,7'h40,7'h30,7'h40,7'h3C};
			7'd88: font_rom = {7'h44,7'h28,7'h10,7'h28,7'h44};
			7'd89: font_rom = {7'h0C,7'h50,7'h50,7'h50,7'h3C};
			7'd90: font_rom = {7'h44,7'h64,7'h54,7'h4C,7'h44};
			7'd91: font_rom = {7'h00,7'h08,7'h36,7'h41,7'h00};
			7'd92: font_rom = {7'h00,7'h00,7'h7F,7'h00,7'h00};
			7'd93: font_rom = {7'h00,7'h41,7'h36,7'h08,7'h00};
			7'd94: font_rom = {7'h10,7'h08,7'h08,7'h10,7'h10};
			default: font_rom = '0;
		endcase
	endfunction

endpackage

// ===== design/btgr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btgr_front
// Accepts text bytes, classifies them, keeps the cursor and queues glyphs.
// ----------------------------------------------------------------------------
module btgr_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          text_byte,
	input  logic                                string_start,
	input  btgr_pkg::coord_t                    start_x,
	input  logic [btgr_pkg::SCALE_BITS-1:0]     scale,
	input  logic                                q_full,
	output logic                                q_push,
	output btgr_pkg::glyph_entry_t              q_entry
);

	btgr_pkg::coord_t                   cursor_q;
	btgr_pkg::coord_t                   base_x;
	logic [btgr_pkg::OFFS_BITS-1:0]     advance;
	logic                               accept;
	logic                               is_print;
	logic                               is_lead;
	logic                               is_cont;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign is_print = (text_byte >= btgr_pkg::FIRST_PRINT) && (text_byte <= btgr_pkg::LAST_PRINT);
	assign is_lead  = (text_byte >= btgr_pkg::LEAD_LOW) && (text_byte <= btgr_pkg::LEAD_HIGH);
	assign is_cont  = (text_byte[7:6] == btgr_pkg::CONT_TAG);

	// reload happens even for bytes that end up skipped
	assign base_x  = string_start ? start_x : cursor_q;
	// 6 * scale = 4 * scale + 2 * scale
	assign advance = {1'b0, scale, 2'b00} + {2'b00, scale, 1'b0};

	always_comb begin
		q_entry.base_x = base_x;
		if (is_print)
			q_entry.glyph = btgr_pkg::GLYPH_BITS'(text_byte - btgr_pkg::FIRST_PRINT);
		else
			q_entry.glyph = btgr_pkg::QMARK_GLYPH;
	end

	assign q_push = accept && (is_print || is_lead);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (accept) begin
			if (is_cont)
				cursor_q <= base_x;
			else
				cursor_q <= btgr_pkg::sat_add(base_x, advance);
		end
	end

endmodule

// ===== design/btgr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btgr_queue
// Small first-in first-out queue of glyphs between front and back.
// ----------------------------------------------------------------------------
module btgr_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  btgr_pkg::glyph_entry_t  push_entry,
	output logic                    full,
	input  logic                    pop,
	output logic                    not_empty,
	output btgr_pkg::glyph_entry_t  head
);

	btgr_pkg::glyph_entry_t             slot_q [btgr_pkg::QDEPTH];
	logic [btgr_pkg::QPTR_BITS-1:0]     wr_ptr_q;
	logic [btgr_pkg::QPTR_BITS-1:0]     rd_ptr_q;
	logic [btgr_pkg::QPTR_BITS:0]       count_q;

	assign full      = (count_q == (btgr_pkg::QPTR_BITS+1)'(btgr_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/btgr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btgr_back
// Steps through the five columns of the head glyph into the output register.
// ----------------------------------------------------------------------------
module btgr_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_not_empty,
	input  btgr_pkg::glyph_entry_t              q_head,
	output logic                                q_pop,
	input  btgr_pkg::coord_t                    start_y,
	input  logic [btgr_pkg::SCALE_BITS-1:0]     scale,
	output logic                                out_valid,
	input  logic                                out_ready,
	output btgr_pkg::coord_t                    column_x,
	output btgr_pkg::coord_t                    row_y,
	output logic [btgr_pkg::MASK_BITS-1:0]      row_mask,
	output logic [btgr_pkg::SCALE_BITS-1:0]     dot_scale,
	output logic [btgr_pkg::COL_BITS-1:0]       column_index,
	output logic                                last_column
);

	logic [btgr_pkg::COL_BITS-1:0]      col_q;
	logic                               out_valid_q;
	logic                               step;
	logic                               is_last;
	logic [btgr_pkg::OFFS_BITS-1:0]     col_offs;
	btgr_pkg::glyph_cols_t              cols;

	btgr_pkg::coord_t                   column_x_q;
	btgr_pkg::coord_t                   row_y_q;
	logic [btgr_pkg::MASK_BITS-1:0]     row_mask_q;
	logic [btgr_pkg::SCALE_BITS-1:0]    dot_scale_q;
	logic [btgr_pkg::COL_BITS-1:0]      column_index_q;
	logic                               last_column_q;

	assign step     = q_not_empty && (!out_valid_q || out_ready);
	assign is_last  = (col_q == btgr_pkg::LAST_COL);
	assign q_pop    = step && is_last;
	// both factors widened so the product keeps all of 4 * 15
	assign col_offs = {{(btgr_pkg::OFFS_BITS-btgr_pkg::COL_BITS){1'b0}}, col_q} *
		{{(btgr_pkg::OFFS_BITS-btgr_pkg::SCALE_BITS){1'b0}}, scale};
	assign cols     = btgr_pkg::font_rom(q_head.glyph);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step)
				col_q <= is_last ? '0 : col_q + 1'b1;
			if (step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			column_x_q     <= btgr_pkg::sat_add(q_head.base_x, col_offs);
			row_y_q        <= start_y;
			row_mask_q     <= cols[btgr_pkg::LAST_COL - col_q];
			dot_scale_q    <= scale;
			column_index_q <= col_q;
			last_column_q  <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign column_x     = column_x_q;
	assign row_y        = row_y_q;
	assign row_mask     = row_mask_q;
	assign dot_scale    = dot_scale_q;
	assign column_index = column_index_q;
	assign last_column  = last_column_q;

endmodule

// ===== design/bitmap_text_glyph_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_text_glyph_rasterizer
// 5x7 character generator: text bytes in, positioned glyph columns out.
// ----------------------------------------------------------------------------
// A byte word is taken whenever the four-entry glyph queue has room; the
// front end updates the cursor in that same cycle. Bytes that draw nothing
// (controls, 127, 0xFE/0xFF, UTF-8 continuation bytes) queue no glyph. A
// printable byte or a UTF-8 lead byte (drawn as '?') queues one glyph, and
// the back end turns each glyph into five column words, one per cycle while
// out_ready is high, through a registered output stage, so a stream of drawn
// characters is paced by the back end's column counter. When the queue is
// empty, the first column of a glyph passes through the queue slot and then
// the output register. The configuration registers (start_x, start_y,
// pixel_scale) may only be written while no word is in flight; pixel_scale
// of zero acts as one and all x positions clamp to the signed 16-bit range.
// ----------------------------------------------------------------------------
module bitmap_text_glyph_rasterizer (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration write port
	input  logic                                    cfg_we,
	input  logic [btgr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [btgr_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
	// byte input
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [7:0]                              text_byte,
	input  logic                                    string_start,
	// column output
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [btgr_pkg::COORD_BITS-1:0]  column_x,
	output logic signed [btgr_pkg::COORD_BITS-1:0]  row_y,
	output logic [btgr_pkg::MASK_BITS-1:0]          row_mask,
	output logic [btgr_pkg::SCALE_BITS-1:0]         dot_scale,
	output logic [btgr_pkg::COL_BITS-1:0]           column_index,
	output logic                                    last_column
);

	// Configuration registers
	btgr_pkg::coord_t                   start_x_q;
	btgr_pkg::coord_t                   start_y_q;
	logic [btgr_pkg::SCALE_BITS-1:0]    pixel_scale_q;
	logic [btgr_pkg::SCALE_BITS-1:0]    eff_scale;

	// Queue hookup
	logic                               q_push;
	logic                               q_pop;
	logic                               q_full;
	logic                               q_not_empty;
	btgr_pkg::glyph_entry_t             q_in;
	btgr_pkg::glyph_entry_t             q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q     <= '0;
			start_y_q     <= '0;
			pixel_scale_q <= btgr_pkg::SCALE_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				btgr_pkg::REG_START_X:
					start_x_q <= cfg_wdata[btgr_pkg::COORD_BITS-1:0];
				btgr_pkg::REG_START_Y:
					start_y_q <= cfg_wdata[btgr_pkg::COORD_BITS-1:0];
				btgr_pkg::REG_PIXEL_SCALE:
					pixel_scale_q <= cfg_wdata[btgr_pkg::SCALE_BITS-1:0];
				default: ;   // unused index: write is dropped
			endcase
		end
	end

	// zero scale draws like scale one
	assign eff_scale = (pixel_scale_q == '0) ? btgr_pkg::SCALE_BITS'(1) : pixel_scale_q;

	// Front: classify bytes, run the cursor, queue glyphs
	btgr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.string_start (string_start),
		.start_x      (start_x_q),
		.scale        (eff_scale),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_in)
	);

	// Glyph queue decouples byte intake from column output
	btgr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	// Back: five column words per glyph
	btgr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.start_y      (start_y_q),
		.scale        (eff_scale),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.column_x     (column_x),
		.row_y        (row_y),
		.row_mask     (row_mask),
		.dot_scale    (dot_scale),
		.column_index (column_index),
		.last_column  (last_column)
	);

endmodule
